// ----- rtl/stdp_trace_synapse_update_assert.svh -----
// Assertion macros shared by the STDP trace synapse block.
// Needs clk and rst_n in the scope of each use.
`ifndef STDP_TRACE_SYNAPSE_UPDATE_ASSERT_SVH
`define STDP_TRACE_SYNAPSE_UPDATE_ASSERT_SVH

// cond holds at every clock edge out of reset
`define STU_ALWAYS(lbl, cond, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define STU_IMPLY(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define STU_NEXT(lbl, ante, cons, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/stu_pkg.sv -----
// Shared types, codes and arithmetic helpers for the STDP trace synapse block.
// No dependencies.
package stu_pkg;

    typedef enum logic [2:0] {
        FUNC_LOAD = 3'd0,
        FUNC_PRE  = 3'd1,
        FUNC_POST = 3'd2,
        FUNC_TICK = 3'd3,
        FUNC_READ = 3'd4
    } func_t;

    localparam logic [1:0] CFG_DSTEP  = 2'd0;
    localparam logic [1:0] CFG_DRATE  = 2'd1;
    localparam logic [1:0] CFG_DSTART = 2'd2;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic rd_out;
        logic p_init;
        logic p_scan;
        logic p_hit;
        logic p_upd;
        logic q_init;
        logic q_scan;
        logic s_init;
        logic s_sweep;
        logic d_decay;
        logic t_out;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic p_done;
        logic p_found;
        logic q_done;
        logic s_done;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Q16.16 trace times Q0.16 rate, exact
    function automatic logic signed [48:0] rate_prod(input logic signed [31:0] tr,
                                                     input logic [15:0] rate);
        logic signed [48:0] a;
        logic signed [48:0] b;
        a = {{17{tr[31]}}, tr};
        b = {33'd0, rate};
        return a * b;
    endfunction

    // product over 65536, rounded toward zero
    function automatic logic signed [31:0] rate_dec(input logic signed [48:0] p);
        logic signed [48:0] t;
        if (p < 0)
            t = (p + 49'sd65535) >>> 16;
        else
            t = p >>> 16;
        return t[31:0];
    endfunction

endpackage

// ----- rtl/stu_ctrl.sv -----
// Sequencer for the STDP trace synapse block.
// Uses stu_pkg command and status structs; drives stu_datapath.
module stu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2:0]      func,
    input  stu_pkg::stat_t  stat,
    output stu_pkg::cmd_t   cmd,
    output logic            busy
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_RDOUT = 13'b0000000000100,
        S_PINIT = 13'b0000000001000,
        S_PSCAN = 13'b0000000010000,
        S_PHIT  = 13'b0000000100000,
        S_PUPD  = 13'b0000001000000,
        S_QINIT = 13'b0000010000000,
        S_QSCAN = 13'b0000100000000,
        S_SINIT = 13'b0001000000000,
        S_SWEEP = 13'b0010000000000,
        S_DDEC  = 13'b0100000000000,
        S_TOUT  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = start && (state_reg == S_IDLE);
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.rd_out     = (state_reg == S_RDOUT);
        cmd.p_init     = (state_reg == S_PINIT);
        cmd.p_scan     = (state_reg == S_PSCAN);
        cmd.p_hit      = (state_reg == S_PHIT);
        cmd.p_upd      = (state_reg == S_PUPD);
        cmd.q_init     = (state_reg == S_QINIT);
        cmd.q_scan     = (state_reg == S_QSCAN);
        cmd.s_init     = (state_reg == S_SINIT);
        cmd.s_sweep    = (state_reg == S_SWEEP);
        cmd.d_decay    = (state_reg == S_DDEC);
        cmd.t_out      = (state_reg == S_TOUT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start && func == stu_pkg::FUNC_READ)
                    state_next = S_RDOUT;
                else if (start && func == stu_pkg::FUNC_TICK)
                    state_next = S_PINIT;
            end
            S_RDOUT: state_next = S_IDLE;
            S_PINIT: state_next = S_PSCAN;
            S_PSCAN:
            begin
                if (stat.p_done)
                    state_next = stat.p_found ? S_PHIT : S_QINIT;
            end
            S_PHIT:  state_next = S_PUPD;
            S_PUPD:  state_next = S_PINIT;
            S_QINIT: state_next = S_QSCAN;
            S_QSCAN: if (stat.q_done) state_next = S_SINIT;
            S_SINIT: state_next = S_SWEEP;
            S_SWEEP: if (stat.s_done) state_next = S_DDEC;
            S_DDEC:  state_next = S_TOUT;
            S_TOUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/stu_datapath.sv -----
// Datapath for the STDP trace synapse block: synapse memories, pending spike
// stores, depression trace and result registers. Uses stu_pkg and the assert header.
`include "stdp_trace_synapse_update_assert.svh"

module stu_datapath #(
    parameter int NUM_SYNAPSES = 256,
    parameter int PRE_DEPTH    = 64,
    parameter int POST_DEPTH   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stu_pkg::cmd_t       cmd,
    output stu_pkg::stat_t      stat,
    input  logic [2:0]          func,
    input  logic [7:0]          syn_index,
    input  logic [31:0]         spike_time,
    input  logic signed [31:0]  weight_value,
    input  logic signed [31:0]  trace_step,
    input  logic [15:0]         trace_rate,
    input  logic [31:0]         now_time,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic                result_kind,
    output logic signed [31:0]  activation,
    output logic signed [31:0]  weight_out,
    output logic signed [31:0]  potentiation_out,
    output logic signed [31:0]  depression_out,
    output logic                overflow_flag
);

    localparam int SW  = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
    localparam int SCW = $clog2(NUM_SYNAPSES + 1);
    localparam int PAW = $clog2(PRE_DEPTH);
    localparam int PCW = $clog2(PRE_DEPTH + 1);
    localparam int QAW = (POST_DEPTH > 1) ? $clog2(POST_DEPTH) : 1;
    localparam int QCW = $clog2(POST_DEPTH + 1);
    localparam int MW  = QCW;
    localparam int PMW = 34 + MW;
    localparam int ACW = 34 + PCW;

    // memories
    logic signed [31:0] w_mem  [NUM_SYNAPSES];
    logic signed [31:0] tr_mem [NUM_SYNAPSES];
    logic signed [31:0] st_mem [NUM_SYNAPSES];
    logic [15:0]        rt_mem [NUM_SYNAPSES];
    logic [31:0]        pt_mem [PRE_DEPTH];
    logic [SW-1:0]      ps_mem [PRE_DEPTH];
    logic signed [31:0] pw_mem [PRE_DEPTH];
    logic [31:0]        qt_mem [POST_DEPTH];

    logic signed [31:0] w_q, tr_q, st_q;
    logic [15:0]        rt_q;
    logic [31:0]        pt_q, qt_q;
    logic [SW-1:0]      ps_q;
    logic signed [31:0] pw_q;

    // registers
    logic signed [31:0] dstep_reg, dtrace_reg;
    logic [15:0]        drate_reg;
    logic               dropped_reg;
    logic [31:0]        now_reg;
    logic               rd_ok_reg;
    logic signed [ACW-1:0] act_reg;
    logic [SCW-1:0]     clr_cnt_reg;

    logic [PCW-1:0]     pre_cnt_reg, p_rd_reg, p_wr_reg;
    logic               p_v_reg;
    logic [PAW-1:0]     p_ix_reg;
    logic               rm_v_reg;
    logic [PAW-1:0]     rm_ix_reg;
    logic               found_reg;
    logic [31:0]        best_t_reg;
    logic [SW-1:0]      best_syn_reg;
    logic signed [31:0] best_w_reg;
    logic [PAW-1:0]     best_ix_reg;

    logic [QCW-1:0]     q_cnt_reg, q_rd_reg, q_wr_reg;
    logic               q_v_reg;
    logic [MW-1:0]      m_reg;

    logic [SCW-1:0]     s_cnt_reg;
    logic               v1_reg, v2_reg;
    logic [SW-1:0]      a1_reg, a2_reg;
    logic signed [PMW-1:0] pm_reg;
    logic signed [48:0] pr_reg;
    logic signed [31:0] w2_reg, t2_reg;

    logic               done_reg, kind_reg, flag_reg;
    logic signed [31:0] act_out_reg, wout_reg, pout_reg, dout_reg;

    // decode
    logic               syn_ok;
    logic [SW-1:0]      sidx;
    logic               pre_full, post_full;
    logic               ins_pre, ins_post;
    logic               p_keep, q_due;
    logic               p_better;
    logic signed [31:0] act_sat;

    assign syn_ok    = ({24'd0, syn_index} < 32'(NUM_SYNAPSES));
    assign sidx      = SW'({24'd0, syn_index});
    assign pre_full  = (pre_cnt_reg == PCW'(PRE_DEPTH));
    assign post_full = (q_cnt_reg == QCW'(POST_DEPTH));
    assign ins_pre   = cmd.accept && func == stu_pkg::FUNC_PRE && syn_ok && !pre_full;
    assign ins_post  = cmd.accept && func == stu_pkg::FUNC_POST && !post_full;
    assign p_keep    = cmd.p_scan && p_v_reg && !(rm_v_reg && p_ix_reg == rm_ix_reg);
    assign p_better  = (pt_q <= now_reg) && (!found_reg || pt_q < best_t_reg);
    assign q_due     = (qt_q <= now_reg);
    assign act_sat   = stu_pkg::sat32(64'(act_reg));

    assign stat.clear_done = cmd.clear_step && (clr_cnt_reg == SCW'(NUM_SYNAPSES - 1));
    assign stat.p_done     = cmd.p_scan && (p_rd_reg == pre_cnt_reg) && !p_v_reg;
    assign stat.p_found    = found_reg;
    assign stat.q_done     = cmd.q_scan && (q_rd_reg == q_cnt_reg) && !q_v_reg;
    assign stat.s_done     = cmd.s_sweep && (s_cnt_reg == SCW'(NUM_SYNAPSES))
                             && !v1_reg && !v2_reg;

    // synapse port selection
    logic [SW-1:0]      syn_ra, syn_wa;
    logic               w_we, tr_we, cfg_we;
    logic signed [31:0] w_wd, tr_wd, st_wd;
    logic [15:0]        rt_wd;
    logic signed [PMW-1:0] am, bm;
    logic signed [63:0] wsum;

    always_comb
    begin
        syn_ra = SW'(s_cnt_reg);
        if (cmd.accept)
            syn_ra = sidx;
        else if (cmd.p_hit)
            syn_ra = best_syn_reg;

        am   = {{(PMW - 32){tr_q[31]}}, tr_q};
        bm   = {{(PMW - MW){1'b0}}, m_reg};
        wsum = stu_pkg::sx64(w2_reg) + {{(64 - PMW){pm_reg[PMW-1]}}, pm_reg};

        w_we   = 1'b0;
        tr_we  = 1'b0;
        cfg_we = 1'b0;
        syn_wa = a2_reg;
        w_wd   = stu_pkg::sat32(wsum);
        tr_wd  = t2_reg - stu_pkg::rate_dec(pr_reg);
        st_wd  = trace_step;
        rt_wd  = trace_rate;
        if (cmd.clear_step)
        begin
            w_we   = 1'b1;
            tr_we  = 1'b1;
            cfg_we = 1'b1;
            syn_wa = SW'(clr_cnt_reg);
            w_wd   = '0;
            tr_wd  = '0;
            st_wd  = '0;
            rt_wd  = '0;
        end
        else if (cmd.accept && func == stu_pkg::FUNC_LOAD && syn_ok)
        begin
            w_we   = 1'b1;
            tr_we  = 1'b1;
            cfg_we = 1'b1;
            syn_wa = sidx;
            w_wd   = weight_value;
            tr_wd  = '0;
        end
        else if (cmd.p_upd)
        begin
            w_we   = 1'b1;
            tr_we  = 1'b1;
            syn_wa = best_syn_reg;
            w_wd   = stu_pkg::sat32(stu_pkg::sx64(best_w_reg) + stu_pkg::sx64(dtrace_reg));
            tr_wd  = stu_pkg::sat32(stu_pkg::sx64(tr_q) + stu_pkg::sx64(st_q));
        end
        else if (v2_reg)
        begin
            w_we  = 1'b1;
            tr_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[syn_wa] <= w_wd;
        if (tr_we)
            tr_mem[syn_wa] <= tr_wd;
        if (cfg_we)
        begin
            st_mem[syn_wa] <= st_wd;
            rt_mem[syn_wa] <= rt_wd;
        end
        w_q  <= w_mem[syn_ra];
        tr_q <= tr_mem[syn_ra];
        st_q <= st_mem[syn_ra];
        rt_q <= rt_mem[syn_ra];
    end

    // pending stores: insert at the tail, compact on each scan pass
    always_ff @(posedge clk)
    begin
        if (ins_pre)
        begin
            pt_mem[PAW'(pre_cnt_reg)] <= spike_time;
            ps_mem[PAW'(pre_cnt_reg)] <= sidx;
            pw_mem[PAW'(pre_cnt_reg)] <= weight_value;
        end
        else if (p_keep)
        begin
            pt_mem[PAW'(p_wr_reg)] <= pt_q;
            ps_mem[PAW'(p_wr_reg)] <= ps_q;
            pw_mem[PAW'(p_wr_reg)] <= pw_q;
        end
        pt_q <= pt_mem[PAW'(p_rd_reg)];
        ps_q <= ps_mem[PAW'(p_rd_reg)];
        pw_q <= pw_mem[PAW'(p_rd_reg)];

        if (ins_post)
            qt_mem[QAW'(q_cnt_reg)] <= spike_time;
        else if (cmd.q_scan && q_v_reg && !q_due)
            qt_mem[QAW'(q_wr_reg)] <= qt_q;
        qt_q <= qt_mem[QAW'(q_rd_reg)];
    end

    // sweep pipeline payload
    always_ff @(posedge clk)
    begin
        pm_reg <= am * bm;
        pr_reg <= stu_pkg::rate_prod(tr_q, rt_q);
        w2_reg <= w_q;
        t2_reg <= tr_q;
        a2_reg <= a1_reg;
        a1_reg <= SW'(s_cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstep_reg    <= '0;
            drate_reg    <= '0;
            dtrace_reg   <= '0;
            dropped_reg  <= 1'b0;
            now_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            act_reg      <= '0;
            clr_cnt_reg  <= '0;
            pre_cnt_reg  <= '0;
            p_rd_reg     <= '0;
            p_wr_reg     <= '0;
            p_v_reg      <= 1'b0;
            p_ix_reg     <= '0;
            rm_v_reg     <= 1'b0;
            rm_ix_reg    <= '0;
            found_reg    <= 1'b0;
            best_t_reg   <= '0;
            best_syn_reg <= '0;
            best_w_reg   <= '0;
            best_ix_reg  <= '0;
            q_cnt_reg    <= '0;
            q_rd_reg     <= '0;
            q_wr_reg     <= '0;
            q_v_reg      <= 1'b0;
            m_reg        <= '0;
            s_cnt_reg    <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            done_reg     <= 1'b0;
            kind_reg     <= 1'b0;
            flag_reg     <= 1'b0;
            act_out_reg  <= '0;
            wout_reg     <= '0;
            pout_reg     <= '0;
            dout_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    stu_pkg::CFG_DSTEP:  dstep_reg <= cfg_data;
                    stu_pkg::CFG_DRATE:  drate_reg <= cfg_data[15:0];
                    stu_pkg::CFG_DSTART: dtrace_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (cmd.accept)
            begin
                case (func)
                    stu_pkg::FUNC_PRE:
                    begin
                        if (syn_ok && pre_full)
                            dropped_reg <= 1'b1;
                        else if (syn_ok)
                            pre_cnt_reg <= pre_cnt_reg + 1'b1;
                    end
                    stu_pkg::FUNC_POST:
                    begin
                        if (post_full)
                            dropped_reg <= 1'b1;
                        else
                            q_cnt_reg <= q_cnt_reg + 1'b1;
                    end
                    stu_pkg::FUNC_TICK:
                    begin
                        act_reg <= '0;
                        now_reg <= now_time;
                    end
                    stu_pkg::FUNC_READ: rd_ok_reg <= syn_ok;
                    default: ;
                endcase
            end

            // pre store pass: compact and pick the earliest due spike
            if (cmd.p_init)
            begin
                p_rd_reg  <= '0;
                p_wr_reg  <= '0;
                p_v_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            if (cmd.p_scan)
            begin
                p_v_reg <= (p_rd_reg != pre_cnt_reg);
                if (p_rd_reg != pre_cnt_reg)
                    p_rd_reg <= p_rd_reg + 1'b1;
                p_ix_reg <= PAW'(p_rd_reg);
                if (p_keep)
                begin
                    p_wr_reg <= p_wr_reg + 1'b1;
                    if (p_better)
                    begin
                        found_reg    <= 1'b1;
                        best_t_reg   <= pt_q;
                        best_syn_reg <= ps_q;
                        best_w_reg   <= pw_q;
                        best_ix_reg  <= PAW'(p_wr_reg);
                    end
                end
                if (stat.p_done)
                begin
                    pre_cnt_reg <= p_wr_reg;
                    if (!found_reg)
                        rm_v_reg <= 1'b0;
                end
            end
            if (cmd.p_hit)
            begin
                rm_v_reg  <= 1'b1;
                rm_ix_reg <= best_ix_reg;
            end
            if (cmd.p_upd)
                act_reg <= act_reg + ACW'(best_w_reg);

            // post store pass: count due spikes and step the depression trace
            if (cmd.q_init)
            begin
                q_rd_reg <= '0;
                q_wr_reg <= '0;
                q_v_reg  <= 1'b0;
                m_reg    <= '0;
            end
            if (cmd.q_scan)
            begin
                q_v_reg <= (q_rd_reg != q_cnt_reg);
                if (q_rd_reg != q_cnt_reg)
                    q_rd_reg <= q_rd_reg + 1'b1;
                if (q_v_reg && q_due)
                begin
                    m_reg      <= m_reg + 1'b1;
                    dtrace_reg <= stu_pkg::sat32(stu_pkg::sx64(dtrace_reg)
                                                 + stu_pkg::sx64(dstep_reg));
                end
                else if (q_v_reg)
                    q_wr_reg <= q_wr_reg + 1'b1;
                if (stat.q_done)
                    q_cnt_reg <= q_wr_reg;
            end

            // synapse sweep: weight += m * trace, then trace decay
            if (cmd.s_init)
                s_cnt_reg <= '0;
            v1_reg <= cmd.s_sweep && (s_cnt_reg != SCW'(NUM_SYNAPSES));
            v2_reg <= v1_reg;
            if (cmd.s_sweep && s_cnt_reg != SCW'(NUM_SYNAPSES))
                s_cnt_reg <= s_cnt_reg + 1'b1;

            if (cmd.d_decay)
                dtrace_reg <= dtrace_reg
                              - stu_pkg::rate_dec(stu_pkg::rate_prod(dtrace_reg, drate_reg));

            if (cmd.rd_out)
            begin
                done_reg    <= 1'b1;
                kind_reg    <= 1'b1;
                act_out_reg <= '0;
                wout_reg    <= rd_ok_reg ? w_q : 32'sd0;
                pout_reg    <= rd_ok_reg ? tr_q : 32'sd0;
                dout_reg    <= dtrace_reg;
                flag_reg    <= dropped_reg;
            end
            if (cmd.t_out && act_reg != 0)
            begin
                done_reg    <= 1'b1;
                kind_reg    <= 1'b0;
                act_out_reg <= act_sat;
                wout_reg    <= '0;
                pout_reg    <= '0;
                dout_reg    <= dtrace_reg;
                flag_reg    <= dropped_reg;
            end
        end
    end

    assign done             = done_reg;
    assign result_kind      = kind_reg;
    assign activation       = act_out_reg;
    assign weight_out       = wout_reg;
    assign potentiation_out = pout_reg;
    assign depression_out   = dout_reg;
    assign overflow_flag    = flag_reg;

    `STU_ALWAYS(a_pre_bound, pre_cnt_reg <= PCW'(PRE_DEPTH), "pre store count past depth")
    `STU_ALWAYS(a_post_bound, q_cnt_reg <= QCW'(POST_DEPTH), "post store count past depth")
    `STU_NEXT(a_done_single, done_reg, !done_reg, "result strobe held for two cycles")
    `STU_IMPLY(a_hit_found, cmd.p_hit, found_reg && !p_v_reg, "pre handler without due spike")

endmodule

// ----- rtl/stdp_trace_synapse_update.sv -----
// Top level of the STDP trace synapse block.
// Joins stu_ctrl and stu_datapath; uses stu_pkg.
//
//  channel   handshake                 beat content
//  -------   ---------                 ------------
//  command   start / busy              func, syn_index, spike_time, weight_value,
//                                      trace_step, trace_rate, now_time
//  result    done (one-cycle strobe)   result_kind, activation, weight_out,
//                                      potentiation_out, depression_out, overflow_flag
//  config    cfg_write                 cfg_index, cfg_data
//
// Load, pre and post beats are taken at acceptance; a read passes through the read-out
// state and then strobes done. A tick runs one pre store scan per due pre spike and a
// last one that finds none, then one scan of the post store, then one pass over the
// synapse memories.
// After reset the synapse memories are cleared while busy is high.
// Results cannot be stalled: each is shown for exactly one cycle.
module stdp_trace_synapse_update #(
    parameter int NUM_SYNAPSES = 256,
    parameter int PRE_DEPTH    = 64,
    parameter int POST_DEPTH   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic [7:0]          syn_index,
    input  logic [31:0]         spike_time,
    input  logic signed [31:0]  weight_value,
    input  logic signed [31:0]  trace_step,
    input  logic [15:0]         trace_rate,
    input  logic [31:0]         now_time,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic                result_kind,
    output logic signed [31:0]  activation,
    output logic signed [31:0]  weight_out,
    output logic signed [31:0]  potentiation_out,
    output logic signed [31:0]  depression_out,
    output logic                overflow_flag
);

    stu_pkg::cmd_t  cmd;
    stu_pkg::stat_t stat;

    stu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    stu_datapath #(
        .NUM_SYNAPSES (NUM_SYNAPSES),
        .PRE_DEPTH    (PRE_DEPTH),
        .POST_DEPTH   (POST_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .func             (func),
        .syn_index        (syn_index),
        .spike_time       (spike_time),
        .weight_value     (weight_value),
        .trace_step       (trace_step),
        .trace_rate       (trace_rate),
        .now_time         (now_time),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .result_kind      (result_kind),
        .activation       (activation),
        .weight_out       (weight_out),
        .potentiation_out (potentiation_out),
        .depression_out   (depression_out),
        .overflow_flag    (overflow_flag)
    );

endmodule

// ----- bench/stu_checker.sv -----
// Checker for the STDP trace synapse block: watches command, config and result beats,
// predicts each result and compares it field by field. Depends on stu_pkg.
`timescale 1ns / 1ps

module stu_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         func,
    input  logic [7:0]         syn_index,
    input  logic [31:0]        spike_time,
    input  logic signed [31:0] weight_value,
    input  logic signed [31:0] trace_step,
    input  logic [15:0]        trace_rate,
    input  logic [31:0]        now_time,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               done,
    input  logic               result_kind,
    input  logic signed [31:0] activation,
    input  logic signed [31:0] weight_out,
    input  logic signed [31:0] potentiation_out,
    input  logic signed [31:0] depression_out,
    input  logic               overflow_flag,
    output int                 fails,
    output int                 waiting
);

    localparam int NSYN = 256;
    localparam int NPRE = 64;
    localparam int NPOST = 16;

    typedef struct packed {
        logic        kind;
        logic [31:0] act;
        logic [31:0] wgt;
        logic [31:0] pot;
        logic [31:0] dep;
        logic        ovf;
    } synapse_beat_t;

    synapse_beat_t expected_beats[$];

    logic signed [31:0] syn_w  [NSYN];
    logic signed [31:0] syn_tr [NSYN];
    logic signed [31:0] syn_st [NSYN];
    logic [15:0]        syn_rt [NSYN];
    logic [31:0]        pre_t  [NPRE];
    logic [7:0]         pre_s  [NPRE];
    logic signed [31:0] pre_w  [NPRE];
    int                 pre_n;
    logic [31:0]        post_t [NPOST];
    int                 post_n;
    logic signed [31:0] dep_tr;
    logic signed [31:0] dep_step;
    logic [15:0]        dep_rate;
    logic               lost_spike;

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // integer division truncates toward zero, as the decay requires
    function automatic logic signed [31:0] leak(input logic signed [31:0] tr,
                                                 input logic [15:0] rate);
        longint prod;
        prod = longint'(tr) * longint'({16'd0, rate});
        return tr - 32'(prod / 65536);
    endfunction

    function automatic void run_tick(input logic [31:0] now);
        longint act;
        int best;
        int n;
        logic [7:0] s;
        synapse_beat_t b;
        act = 0;
        while (1)
        begin
            best = -1;
            for (int i = 0; i < pre_n; i++)
                if (pre_t[i] <= now && (best < 0 || pre_t[i] < pre_t[best]))
                    best = i;
            if (best < 0)
                break;
            s = pre_s[best];
            act += longint'(pre_w[best]);
            syn_tr[s] = clamp_q16(longint'(syn_tr[s]) + longint'(syn_st[s]));
            syn_w[s]  = clamp_q16(longint'(pre_w[best]) + longint'(dep_tr));
            for (int i = best; i < pre_n - 1; i++)
            begin
                pre_t[i] = pre_t[i+1];
                pre_s[i] = pre_s[i+1];
                pre_w[i] = pre_w[i+1];
            end
            pre_n--;
        end
        n = 0;
        for (int i = 0; i < post_n; i++)
        begin
            if (post_t[i] <= now)
            begin
                dep_tr = clamp_q16(longint'(dep_tr) + longint'(dep_step));
                for (int k = 0; k < NSYN; k++)
                    syn_w[k] = clamp_q16(longint'(syn_w[k]) + longint'(syn_tr[k]));
            end
            else
            begin
                post_t[n] = post_t[i];
                n++;
            end
        end
        post_n = n;
        for (int k = 0; k < NSYN; k++)
            syn_tr[k] = leak(syn_tr[k], syn_rt[k]);
        dep_tr = leak(dep_tr, dep_rate);
        if (act != 0)
        begin
            b = '{1'b0, clamp_q16(act), 32'd0, 32'd0, dep_tr, lost_spike};
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void field_check(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        synapse_beat_t b;
        if (!rst_n)
        begin
            for (int k = 0; k < NSYN; k++)
            begin
                syn_w[k] = 0;
                syn_tr[k] = 0;
                syn_st[k] = 0;
                syn_rt[k] = 0;
            end
            pre_n = 0;
            post_n = 0;
            dep_tr = 0;
            dep_step = 0;
            dep_rate = 0;
            lost_spike = 1'b0;
            expected_beats.delete();
            fails = 0;
        end
        else
        begin
            // compare the result beat first: it was produced before this edge's command
            if (done)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual act %h w %h",
                             $time, activation, weight_out);
                    fails++;
                end
                else
                begin
                    b = expected_beats.pop_front();
                    field_check("result_kind", 32'(b.kind), 32'(result_kind));
                    field_check("activation", b.act, activation);
                    field_check("weight_out", b.wgt, weight_out);
                    field_check("potentiation_out", b.pot, potentiation_out);
                    field_check("depression_out", b.dep, depression_out);
                    field_check("overflow_flag", 32'(b.ovf), 32'(overflow_flag));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == stu_pkg::CFG_DSTEP)
                    dep_step = cfg_data;
                else if (cfg_index == stu_pkg::CFG_DRATE)
                    dep_rate = cfg_data[15:0];
                else if (cfg_index == stu_pkg::CFG_DSTART)
                    dep_tr = cfg_data;
            end
            if (start && !busy)
            begin
                case (func)
                    stu_pkg::FUNC_LOAD:
                    begin
                        syn_w[syn_index]  = weight_value;
                        syn_st[syn_index] = trace_step;
                        syn_rt[syn_index] = trace_rate;
                        syn_tr[syn_index] = 0;
                    end
                    stu_pkg::FUNC_PRE:
                    begin
                        if (pre_n >= NPRE)
                            lost_spike = 1'b1;
                        else
                        begin
                            pre_t[pre_n] = spike_time;
                            pre_s[pre_n] = syn_index;
                            pre_w[pre_n] = weight_value;
                            pre_n++;
                        end
                    end
                    stu_pkg::FUNC_POST:
                    begin
                        if (post_n >= NPOST)
                            lost_spike = 1'b1;
                        else
                        begin
                            post_t[post_n] = spike_time;
                            post_n++;
                        end
                    end
                    stu_pkg::FUNC_TICK:
                        run_tick(now_time);
                    stu_pkg::FUNC_READ:
                    begin
                        b = '{1'b1, 32'd0, syn_w[syn_index], syn_tr[syn_index], dep_tr,
                              lost_spike};
                        expected_beats.push_back(b);
                    end
                    default: ;
                endcase
            end
        end
        waiting = expected_beats.size();
    end

endmodule

// ----- bench/tb_stdp_trace_synapse_update.sv -----
// Top of the STDP trace synapse bench: clock, reset, directed and random command beats,
// config phases and the verdict. Depends on stu_pkg, the block and stu_checker.
`timescale 1ns / 1ps

module tb_stdp_trace_synapse_update;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         func;
    logic [7:0]         syn_index;
    logic [31:0]        spike_time;
    logic signed [31:0] weight_value;
    logic signed [31:0] trace_step;
    logic [15:0]        trace_rate;
    logic [31:0]        now_time;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic               result_kind;
    logic signed [31:0] activation;
    logic signed [31:0] weight_out;
    logic signed [31:0] potentiation_out;
    logic signed [31:0] depression_out;
    logic               overflow_flag;
    int                 fails;
    int                 waiting;
    logic [31:0]        sim_now;

    stdp_trace_synapse_update u_dut (.*);

    stu_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // start stays high across back-to-back beats; lower it only for a real gap
    task automatic send(input logic [2:0] f, input logic [7:0] idx, input logic [31:0] st,
                        input logic [31:0] wv, input logic [31:0] ts, input logic [15:0] tr,
                        input logic [31:0] nw);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        func         <= f;
        syn_index    <= idx;
        spike_time   <= st;
        weight_value <= wv;
        trace_step   <= ts;
        trace_rate   <= tr;
        now_time     <= nw;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every expected beat has come and the block is idle
    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (busy || waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 3))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom_range(0, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_syn();
        return $urandom_range(0, 9) < 7 ? 8'($urandom_range(0, 7)) : 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 19))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom;
            default: return sim_now + $urandom_range(0, 6);
        endcase
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            send(stu_pkg::FUNC_LOAD, pick_syn(), $urandom, pick_q16(), pick_q16(),
                 pick_rate(), $urandom);
        else if (r < 45)
            send(stu_pkg::FUNC_PRE, pick_syn(), pick_time(), pick_q16(), $urandom,
                 16'($urandom), $urandom);
        else if (r < 55)
            send(stu_pkg::FUNC_POST, 8'($urandom), pick_time(), $urandom, $urandom,
                 16'($urandom), $urandom);
        else if (r < 80)
        begin
            sim_now = sim_now + $urandom_range(0, 4);
            send(stu_pkg::FUNC_TICK, 8'($urandom), $urandom, $urandom, $urandom,
                 16'($urandom), sim_now);
        end
        else if (r < 96)
            send(stu_pkg::FUNC_READ, pick_syn(), $urandom, $urandom, $urandom,
                 16'($urandom), $urandom);
        else
            send(3'($urandom_range(5, 7)), 8'($urandom), $urandom, $urandom, $urandom,
                 16'($urandom), $urandom);
    endtask

    // a tick at the top of time clears both pending stores
    task automatic drain();
        send(stu_pkg::FUNC_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
        sim_now = $urandom_range(0, 1000);
    endtask

    initial
    begin
        start = 1'b0;
        func = stu_pkg::FUNC_LOAD;
        syn_index = '0;
        spike_time = '0;
        weight_value = '0;
        trace_step = '0;
        trace_rate = '0;
        now_time = '0;
        cfg_write = 1'b0;
        cfg_index = stu_pkg::CFG_DSTEP;
        cfg_data = '0;
        sim_now = 32'd10;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settle();

        write_cfg(stu_pkg::CFG_DSTEP, 32'h0000_8000);
        write_cfg(stu_pkg::CFG_DRATE, 32'h0000_1000);
        write_cfg(stu_pkg::CFG_DSTART, 32'h7FFF_FFFF);

        // directed: extremes, ties, saturation, idle ticks, unknown codes
        send(stu_pkg::FUNC_LOAD, 8'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'd0);
        send(stu_pkg::FUNC_LOAD, 8'd255, 32'd0, 32'h8000_0000, 32'h8000_0000, 16'h0000, 32'd0);
        send(stu_pkg::FUNC_LOAD, 8'd1, 32'd0, 32'h0001_0000, 32'h0000_4000, 16'h2000, 32'd0);
        send(stu_pkg::FUNC_PRE, 8'd0, 32'd5, 32'h7FFF_FFFF, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_PRE, 8'd0, 32'd5, 32'h7FFF_FFFF, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_PRE, 8'd1, 32'd3, 32'hFFFF_0000, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_PRE, 8'd255, 32'd0, 32'h8000_0000, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_POST, 8'd0, 32'd2, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_POST, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd4);
        send(stu_pkg::FUNC_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_READ, 8'd1, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_READ, 8'd255, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd5);
        send(stu_pkg::FUNC_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd5);
        send(3'd5, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send(3'd6, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send(3'd7, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_TICK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'h0000_0000);
        drain();
        send(stu_pkg::FUNC_READ, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);

        // fill both stores past full so the sticky flag rises
        settle();
        for (int i = 0; i < 66; i++)
            send(stu_pkg::FUNC_PRE, 8'd2, 32'hFFFF_FFFF, 32'($urandom_range(1, 9)), 32'd0,
                 16'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send(stu_pkg::FUNC_POST, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 32'd0);
        send(stu_pkg::FUNC_READ, 8'd2, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_cfg(stu_pkg::CFG_DSTEP, 32'h7FFF_FFFF);
                    write_cfg(stu_pkg::CFG_DRATE, 32'h0000_FFFF);
                    write_cfg(stu_pkg::CFG_DSTART, 32'h8000_0000);
                end
                1:
                begin
                    write_cfg(stu_pkg::CFG_DSTEP, 32'h8000_0000);
                    write_cfg(stu_pkg::CFG_DRATE, 32'h0000_0000);
                    write_cfg(stu_pkg::CFG_DSTART, 32'h0000_0000);
                end
                default:
                begin
                    write_cfg(stu_pkg::CFG_DSTEP, pick_q16());
                    write_cfg(stu_pkg::CFG_DRATE, {16'($urandom), pick_rate()});
                    write_cfg(stu_pkg::CFG_DSTART, pick_q16());
                end
            endcase
            for (int n = 0; n < 225; n++)
            begin
                random_item();
                if (n % 45 == 44)
                    drain();
                if (ph == 2 && n == 100)
                    settle();
            end
            drain();
        end

        settle();
        repeat (50) @(posedge clk);
        if (fails == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/stu_pkg.sv
rtl/stu_ctrl.sv
rtl/stu_datapath.sv
rtl/stdp_trace_synapse_update.sv
bench/stu_checker.sv
bench/tb_stdp_trace_synapse_update.sv
